### rtl/stable_priority_queue_assert.svh
// Assertion macros shared by the priority queue RTL.
`ifndef STABLE_PRIORITY_QUEUE_ASSERT_SVH
`define STABLE_PRIORITY_QUEUE_ASSERT_SVH
`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define SPQ_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Check that a condition leads to a consequence in the next cycle.
`define SPQ_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SPQ_ASSERT(lbl, clk, rst, prop, msg)
`define SPQ_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

### rtl/spq_pkg.sv
// Types and constants shared by the priority queue controller and datapath.
`default_nettype none
package spq_pkg;

  localparam int ID_W       = 8;
  localparam int PRIO_W     = 8;
  localparam int OCC_W      = 5;
  localparam int STATUS_W   = 2;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 24;
  localparam int OUT_PAD_W  = OUT_DATA_W - ID_W - PRIO_W - OCC_W;

  // Request kinds carried on the input tuser bit
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    STS_OK    = 2'd0,
    STS_FULL  = 2'd1,
    STS_EMPTY = 2'd2
  } status_t;

  // Operation applied by the datapath on a transaction
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_FULL   = 2'd2,
    OP_EMPTY  = 2'd3
  } op_t;

  typedef struct packed {
    logic load;
    op_t  op;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } stat_t;

endpackage
`default_nettype wire

### rtl/spq_ctrl.sv
// Controller: handshake, request decode and result-holding state machine.
`default_nettype none
module spq_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_tvalid,
  output logic               s_tready,
  input  wire logic          req_type,
  output logic               m_tvalid,
  input  wire logic          m_tready,
  input  wire spq_pkg::stat_t stat,
  output spq_pkg::cmd_t      cmd
);
  import spq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_HOLD = 2'b10
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  // Take a new transaction whenever the result register is free or draining
  assign s_tready = (state == S_IDLE) || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign m_tvalid = (state == S_HOLD);

  // Decode the request against the current fill state
  always_comb begin
    cmd.load = accept;
    priority if (req_type == REQ_INSERT) begin
      cmd.op = stat.full ? OP_FULL : OP_INSERT;
    end else begin
      cmd.op = stat.empty ? OP_EMPTY : OP_REMOVE;
    end
  end

  // Advance the result-holding state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) state_next = S_HOLD;
      end
      S_HOLD: begin
        if (accept) state_next = S_HOLD;
        else if (m_tready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

### rtl/spq_datapath.sv
// Datapath: sorted shift-register slots, fill count and result register.
`default_nettype none
`include "stable_priority_queue_assert.svh"
module spq_datapath #(
  parameter int CAPACITY = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire spq_pkg::cmd_t            cmd,
  input  wire logic [spq_pkg::ID_W-1:0]   in_id,
  input  wire logic [spq_pkg::PRIO_W-1:0] in_prio,
  output spq_pkg::stat_t                stat,
  output spq_pkg::status_t              res_status,
  output logic [spq_pkg::ID_W-1:0]        res_id,
  output logic [spq_pkg::PRIO_W-1:0]      res_prio,
  output logic [spq_pkg::OCC_W-1:0]       res_occ
);
  import spq_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  logic [ID_W-1:0]   slot_id   [CAPACITY];
  logic [PRIO_W-1:0] slot_prio [CAPACITY];
  logic [CAPACITY-1:0] ge;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;

  assign stat.full  = (count == CW'(CAPACITY));
  assign stat.empty = (count == '0);

  // Mark held slots whose priority is not below the incoming one
  always_comb begin
    for (int k = 0; k < CAPACITY; k++) begin
      ge[k] = (CW'(k) < count) && (slot_prio[k] >= in_prio);
    end
  end

  // Update each slot from itself, its neighbours or the new entry
  for (genvar k = 0; k < CAPACITY; k++) begin : g_slot
    logic take_new;
    if (k == 0) begin : g_head
      assign take_new = !ge[0];
    end else begin : g_body
      assign take_new = !ge[k] && ge[k-1];
    end

    always_ff @(posedge clk) begin
      if (cmd.load && cmd.op == OP_INSERT && !ge[k]) begin
        if (take_new) begin
          slot_id[k]   <= in_id;
          slot_prio[k] <= in_prio;
        end else begin
          slot_id[k]   <= slot_id[(k > 0) ? k - 1 : 0];
          slot_prio[k] <= slot_prio[(k > 0) ? k - 1 : 0];
        end
      end else if (cmd.load && cmd.op == OP_REMOVE && k < CAPACITY - 1) begin
        slot_id[k]   <= slot_id[(k < CAPACITY - 1) ? k + 1 : k];
        slot_prio[k] <= slot_prio[(k < CAPACITY - 1) ? k + 1 : k];
      end
    end
  end

  // Work out the fill count after this transaction
  always_comb begin
    unique case (cmd.op)
      OP_INSERT: count_next = count + CW'(1);
      OP_REMOVE: count_next = count - CW'(1);
      default:   count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.load) begin
      count <= count_next;
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_occ  <= OCC_W'(count_next);
      res_id   <= '0;
      res_prio <= '0;
      unique case (cmd.op)
        OP_INSERT: res_status <= STS_OK;
        OP_REMOVE: begin
          res_status <= STS_OK;
          res_id     <= slot_id[0];
          res_prio   <= slot_prio[0];
        end
        OP_FULL:   res_status <= STS_FULL;
        default:   res_status <= STS_EMPTY;
      endcase
    end
  end

  `SPQ_ASSERT_NEXT(a_insert_grows, clk, rst, cmd.load && cmd.op == OP_INSERT, count == $past(count) + CW'(1), "insert did not grow the count")
  `SPQ_ASSERT_NEXT(a_remove_shrinks, clk, rst, cmd.load && cmd.op == OP_REMOVE, count == $past(count) - CW'(1), "remove did not shrink the count")
  `SPQ_ASSERT_NEXT(a_reject_holds, clk, rst, cmd.load && (cmd.op == OP_FULL || cmd.op == OP_EMPTY), $stable(count), "rejected request changed the count")

endmodule
`default_nettype wire

### rtl/stable_priority_queue.sv
// Top level of the stable priority queue.
//
// Usage: requests arrive on the s_ stream, one per transaction. s_tuser
// selects insert (0) or remove (1); s_tdata carries the entry id and
// priority for an insert. Each request gives exactly one result on the
// m_ stream: m_tuser is the status (ok, full on insert, empty on remove)
// and m_tdata holds the removed entry (zero otherwise) and the occupancy
// after the request.
// An insert is placed ahead of the first held entry with a strictly lower
// priority, so equal priorities leave in arrival order.
// The result is valid in the cycle after the request is accepted.
// Throughput: one request per cycle while the receiver takes each result;
// every slot compares and shifts in the same cycle and the single result register is the only limit.
// A stalled receiver holds the result in that register; a new request is
// taken only in a cycle in which the held result is also taken.
// Reset clears the count and the result register state; the queue is
// empty and ready on the first cycle after reset, with no clearing pass.
`default_nettype none
`include "stable_priority_queue_assert.svh"
module stable_priority_queue #(
  parameter int CAPACITY = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // [7:0] entry_id, [15:8] entry_priority
  input  wire logic [15:0] s_tdata,
  // [0] req_type
  input  wire logic [0:0]  s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // [7:0] out_id, [15:8] out_priority, [20:16] occupancy, [23:21] zero
  output logic [23:0]      m_tdata,
  // [1:0] status
  output logic [1:0]       m_tuser
);
  import spq_pkg::*;

  cmd_t              cmd;
  stat_t             stat;
  status_t           res_status;
  logic [ID_W-1:0]   res_id;
  logic [PRIO_W-1:0] res_prio;
  logic [OCC_W-1:0]  res_occ;

  spq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .req_type (s_tuser[0]),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  spq_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .in_id      (s_tdata[ID_W-1:0]),
    .in_prio    (s_tdata[ID_W+PRIO_W-1:ID_W]),
    .stat       (stat),
    .res_status (res_status),
    .res_id     (res_id),
    .res_prio   (res_prio),
    .res_occ    (res_occ)
  );

  // Pack the result fields
  assign m_tdata = {{OUT_PAD_W{1'b0}}, res_occ, res_prio, res_id};
  assign m_tuser = res_status;

  `SPQ_ASSERT(a_load_on_accept, clk, rst, cmd.load == (s_tvalid && s_tready), "load does not match the input transaction")
  `SPQ_ASSERT(a_no_insert_full, clk, rst, (cmd.load && cmd.op == OP_INSERT) |-> !stat.full, "insert issued while full")
  `SPQ_ASSERT_NEXT(a_result_follows, clk, rst, cmd.load, m_tvalid, "no result after an accepted request")

endmodule
`default_nettype wire
